// ===== sv/gbn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_pkg
// Types, constants and sequence helpers for the Go-Back-N window controller.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // Sequence space and frame framing
  localparam int SEQ_MAX        = 7;
  localparam int SEQ_SPAN       = SEQ_MAX + 1;
  localparam int SEQ_W          = 3;
  localparam int LEN_W          = 9;
  localparam int PAYLOAD_BYTES  = 256;
  localparam int MIN_FRAME_LEN  = 5;
  localparam int FRAME_OVERHEAD = 7;
  // Wide enough to count a full span of released frames
  localparam int REM_W          = $clog2(SEQ_SPAN + 1);

  typedef enum logic [1:0] {
    OP_PACKET  = 2'd0,
    OP_LINK    = 2'd1,
    OP_FRAME   = 2'd2,
    OP_TIMEOUT = 2'd3
  } gbn_op_t;

  typedef enum logic [1:0] {
    ACT_STATUS  = 2'd0,
    ACT_SEND    = 2'd1,
    ACT_DELIVER = 2'd2,
    ACT_STOP    = 2'd3
  } gbn_act_t;

  typedef struct packed {
    gbn_op_t            operation;
    logic [SEQ_W-1:0]   frame_seq;
    logic [SEQ_W-1:0]   rx_ack;
    logic [LEN_W-1:0]   frame_length;
    logic               crc_ok;
  } gbn_in_t;

  typedef struct packed {
    gbn_act_t           action;
    logic [SEQ_W-1:0]   seq_number;
    logic [SEQ_W-1:0]   ack_number;
    logic [LEN_W-1:0]   deliver_length;
    logic               net_enable;
    logic               last;
  } gbn_out_t;

  // Advance a sequence number modulo the span.
  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] k);
    return (k < SEQ_W'(SEQ_MAX)) ? k + SEQ_W'(1) : '0;
  endfunction

  // Distance from a forward to b modulo the span.
  function automatic logic [SEQ_W-1:0] seq_dist(input logic [SEQ_W-1:0] a,
                                                input logic [SEQ_W-1:0] b);
    logic [SEQ_W:0] t;
    if (b >= a) begin
      t = {1'b0, b} - {1'b0, a};
    end else begin
      t = {1'b0, b} + (SEQ_W+1)'(SEQ_SPAN) - {1'b0, a};
    end
    return t[SEQ_W-1:0];
  endfunction

endpackage

// ===== sv/go_back_n_window_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_back_n_window_controller
// Go-Back-N sliding-window link controller with a shared sequence stepper.
// ----------------------------------------------------------------------------
// One request is accepted when start is high and busy is low; it carries one
// link event (packet ready, link ready, received frame, retransmit timeout).
// Each request yields one or more results, each shown on out_result for one
// cycle with out_strobe high; the receiver must take every result as it
// comes, there is no back-pressure. A request that only changes status (link
// ready, full window, bad frame, nothing to release or resend) yields one
// result in the cycle after acceptance and leaves busy low. A request that
// yields n results (send, deliver, releases, resends; n up to 8) keeps busy
// high and puts out one result per cycle, the first after the sequencer
// state and the output register, later than a status-only result:
// a single sequence incrementer steps the send, receive or ack-expected
// counter by one each cycle, under a four-state sequencer.
// net_enable in every result is the window/link status after the whole event.
// ----------------------------------------------------------------------------
module go_back_n_window_controller
  import gbn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  gbn_in_t  in_request,
  output logic     out_strobe,
  output gbn_out_t out_result
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DELIV = 4'b0010,
    ST_REL   = 4'b0100,
    ST_SEND  = 4'b1000
  } state_t;

  state_t             state_r,  state_nxt;
  logic [SEQ_W-1:0]   nts_r,    nts_nxt;   // next to send
  logic [SEQ_W-1:0]   oua_r,    oua_nxt;   // oldest unacked
  logic [SEQ_W-1:0]   exp_r,    exp_nxt;   // expected receive
  logic [SEQ_W-1:0]   cnt_r,    cnt_nxt;   // outstanding count
  logic               link_r,   link_nxt;
  logic [REM_W-1:0]   rem_r,    rem_nxt;   // results left in this burst
  logic               en_r,     en_nxt;    // net_enable for this request
  logic [LEN_W-1:0]   dl_r,     dl_nxt;    // pending deliver length
  logic               ovld_r,   ovld_nxt;
  gbn_out_t           out_r,    out_nxt;

  // Shared sequence stepper
  logic [SEQ_W-1:0]   inc_in, inc_out;

  // Acceptance decode
  logic               accept;
  logic               good_frame;
  logic               in_order;
  logic [SEQ_W-1:0]   ack_dist, win_size;
  logic               ack_in_win;
  logic [REM_W-1:0]   rel_cnt;
  logic [REM_W-1:0]   cnt_ext;
  logic [REM_W-1:0]   cnt_after_rel;
  logic [LEN_W-1:0]   len_trim;
  logic [LEN_W-1:0]   len_cap;
  logic [SEQ_W-1:0]   piggy_ack;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // Pick the counter to step this cycle; only one moves per cycle.
  always_comb begin
    unique case (state_r)
      ST_DELIV: inc_in = exp_r;
      ST_REL:   inc_in = oua_r;
      default:  inc_in = nts_r;
    endcase
  end
  assign inc_out = seq_inc(inc_in);

  // Frame checks: the ack releases (ack - oldest + 1) frames when it falls
  // inside the open window, nothing otherwise.
  assign good_frame = in_request.crc_ok &&
                      (in_request.frame_length >= LEN_W'(MIN_FRAME_LEN));
  assign in_order   = (in_request.frame_seq == exp_r);
  assign ack_dist   = seq_dist(oua_r, in_request.rx_ack);
  assign win_size   = seq_dist(oua_r, nts_r);
  assign ack_in_win = (ack_dist < win_size);
  assign rel_cnt    = ack_in_win ? REM_W'(ack_dist) + REM_W'(1) : '0;
  assign cnt_ext    = REM_W'(cnt_r);
  assign cnt_after_rel = (cnt_ext > rel_cnt) ? cnt_ext - rel_cnt : '0;

  // Payload length: drop header and CRC, floor at zero, cap at buffer size.
  assign len_trim = (in_request.frame_length > LEN_W'(FRAME_OVERHEAD)) ?
                    in_request.frame_length - LEN_W'(FRAME_OVERHEAD) : '0;
  assign len_cap  = (len_trim > LEN_W'(PAYLOAD_BYTES)) ? LEN_W'(PAYLOAD_BYTES)
                                                       : len_trim;

  // Piggybacked ack is one below the expected sequence, modulo the span.
  assign piggy_ack = (exp_r == '0) ? SEQ_W'(SEQ_MAX) : exp_r - SEQ_W'(1);

  always_comb begin
    state_nxt = state_r;
    nts_nxt   = nts_r;
    oua_nxt   = oua_r;
    exp_nxt   = exp_r;
    cnt_nxt   = cnt_r;
    link_nxt  = link_r;
    rem_nxt   = rem_r;
    en_nxt    = en_r;
    dl_nxt    = dl_r;
    ovld_nxt  = 1'b0;
    out_nxt   = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // Status-only result, used unless a burst starts below
          out_nxt.action = ACT_STATUS;
          out_nxt.last   = 1'b1;
          unique case (in_request.operation)
            OP_PACKET: begin
              // Sending always clears link-ready, so net_enable ends low.
              en_nxt = 1'b0;
              if (cnt_r < SEQ_W'(SEQ_MAX)) begin
                cnt_nxt   = cnt_r + SEQ_W'(1);
                rem_nxt   = REM_W'(1);
                state_nxt = ST_SEND;
              end else begin
                ovld_nxt = 1'b1;
              end
            end
            OP_LINK: begin
              link_nxt = 1'b1;
              en_nxt   = (cnt_r < SEQ_W'(SEQ_MAX));
              ovld_nxt = 1'b1;
            end
            OP_FRAME: begin
              if (good_frame) begin
                en_nxt  = (cnt_after_rel < REM_W'(SEQ_MAX)) && link_r;
                dl_nxt  = len_cap;
                rem_nxt = rel_cnt;
                if (in_order) begin
                  state_nxt = ST_DELIV;
                end else if (ack_in_win) begin
                  state_nxt = ST_REL;
                end else begin
                  ovld_nxt = 1'b1;
                end
              end else begin
                en_nxt   = (cnt_r < SEQ_W'(SEQ_MAX)) && link_r;
                ovld_nxt = 1'b1;
              end
            end
            OP_TIMEOUT: begin
              // Rewind and resend every outstanding frame.
              nts_nxt = oua_r;
              rem_nxt = cnt_ext;
              if (cnt_r != '0) begin
                en_nxt    = 1'b0;
                state_nxt = ST_SEND;
              end else begin
                en_nxt   = link_r;
                ovld_nxt = 1'b1;
              end
            end
            default: begin
              ovld_nxt = 1'b1;
            end
          endcase
          out_nxt.net_enable = en_nxt;
        end
      end

      ST_DELIV: begin
        ovld_nxt               = 1'b1;
        out_nxt.action         = ACT_DELIVER;
        out_nxt.seq_number     = exp_r;
        out_nxt.deliver_length = dl_r;
        out_nxt.net_enable     = en_r;
        out_nxt.last           = (rem_r == '0);
        exp_nxt                = inc_out;
        state_nxt              = (rem_r == '0) ? ST_IDLE : ST_REL;
      end

      ST_REL: begin
        ovld_nxt           = 1'b1;
        out_nxt.action     = ACT_STOP;
        out_nxt.seq_number = oua_r;
        out_nxt.net_enable = en_r;
        out_nxt.last       = (rem_r == REM_W'(1));
        oua_nxt            = inc_out;
        cnt_nxt            = (cnt_r != '0) ? cnt_r - SEQ_W'(1) : '0;
        rem_nxt            = rem_r - REM_W'(1);
        if (rem_r == REM_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_SEND: begin
        ovld_nxt           = 1'b1;
        out_nxt.action     = ACT_SEND;
        out_nxt.seq_number = nts_r;
        out_nxt.ack_number = piggy_ack;
        out_nxt.net_enable = en_r;
        out_nxt.last       = (rem_r == REM_W'(1));
        link_nxt           = 1'b0;
        nts_nxt            = inc_out;
        rem_nxt            = rem_r - REM_W'(1);
        if (rem_r == REM_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      nts_r   <= '0;
      oua_r   <= '0;
      exp_r   <= '0;
      cnt_r   <= '0;
      link_r  <= 1'b0;
      rem_r   <= '0;
      en_r    <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nts_r   <= nts_nxt;
      oua_r   <= oua_nxt;
      exp_r   <= exp_nxt;
      cnt_r   <= cnt_nxt;
      link_r  <= link_nxt;
      rem_r   <= rem_nxt;
      en_r    <= en_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    dl_r  <= dl_nxt;
    out_r <= out_nxt;
  end

  assign out_strobe = ovld_r;
  assign out_result = out_r;

`ifndef SYNTH
  // Results of one request come in consecutive cycles.
  a_burst_contig: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_result.last) |=> out_strobe)
    else $error("result burst broken before its last result");

  // A non-final result means the sequencer is still working on the request.
  a_busy_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_result.last) |-> busy)
    else $error("busy low while results are still pending");

  // Sending a frame clears link-ready, so the window cannot be open.
  a_send_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result.action == ACT_SEND) |-> !out_result.net_enable)
    else $error("net_enable high on a send result");

  // A link-ready request answers with exactly one status result next cycle.
  a_link_status: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_request.operation == OP_LINK) |=>
      (out_strobe && out_result.last && out_result.action == ACT_STATUS && !busy))
    else $error("link-ready request did not give a single status result");

  // Outstanding count never exceeds the window.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r <= SEQ_W'(SEQ_MAX)))
    else $error("outstanding count beyond window");
`endif

endmodule

// ===== tb/go_back_n_window_controller_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_back_n_window_controller_test
// Self-checking bench for the Go-Back-N window controller.
// ----------------------------------------------------------------------------
// A short directed run walks the window edge cases first. These are a full
// window, a full-window retransmit, an ack that releases the whole window, short
// and oversized frames, bad and out-of-order frames, an ack outside the window
// and a timeout with nothing in flight. After that about four hundred random
// link events follow, biased toward in-order frames and acks inside the window.
// A clocked driver presents requests at the falling edge with random gaps. At
// the rising edge the monitor mirrors the window counters, queues the results
// it expects and compares every strobed result field by field in order.
// ----------------------------------------------------------------------------
module go_back_n_window_controller_test;
  import gbn_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RANDOM_EVENTS = 387;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int PRINT_LIMIT   = 100;
  localparam int IN_W          = $bits(gbn_in_t);

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  gbn_in_t  in_request;
  logic     out_strobe;
  gbn_out_t out_result;

  // Requests waiting for the driver, and results waiting for the block
  gbn_in_t  pending_requests[$];
  gbn_out_t expected_results[$];

  int queued_count;
  int sent_count;
  int taken_count;
  int gap_left;
  int burst_left;
  int error_count;

  // Mirror of the window counters, advanced on every accepted request
  logic [SEQ_W-1:0] tx_next;
  logic [SEQ_W-1:0] tx_oldest;
  logic [SEQ_W-1:0] rx_expect;
  logic [SEQ_W-1:0] tx_in_flight;
  logic             link_up;

  go_back_n_window_controller uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_request (in_request),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Hold reset low at the start, then release it for good
  initial begin
    rst_n = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Window arithmetic
  // --------------------------------------------------------------------------
  function automatic logic [SEQ_W-1:0] next_seq(input logic [SEQ_W-1:0] k);
    if (k == SEQ_W'(SEQ_MAX)) begin
      return '0;
    end
    return SEQ_W'(k + 1);
  endfunction

  // True when ack lies in the half-open window [base, limit), wrapping
  function automatic bit ack_covers(input logic [SEQ_W-1:0] base,
                                    input logic [SEQ_W-1:0] ack,
                                    input logic [SEQ_W-1:0] limit);
    return (base <= ack && ack < limit) ||
           (limit < base && base <= ack) ||
           (ack < limit && limit < base);
  endfunction

  // Build a send result and drop the link-ready flag, as every send does
  function automatic gbn_out_t build_send(input logic [SEQ_W-1:0] seq);
    gbn_out_t r;
    r            = '0;
    r.action     = ACT_SEND;
    r.seq_number = seq;
    r.ack_number = SEQ_W'((int'(rx_expect) + SEQ_MAX) % SEQ_SPAN);
    link_up      = 1'b0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Predict the results of one accepted request and queue them
  // --------------------------------------------------------------------------
  function automatic void predict_link_event(input gbn_in_t req);
    gbn_out_t         res [SEQ_SPAN];
    int               n;
    int               i;
    int               payload;
    logic [SEQ_W-1:0] resend;
    logic             en;
    n = 0;
    for (i = 0; i < SEQ_SPAN; i++) begin
      res[i] = '0;
    end
    case (req.operation)
      OP_PACKET: begin
        // Reject the packet when the window is already full
        if (tx_in_flight < SEQ_W'(SEQ_MAX)) begin
          tx_in_flight = tx_in_flight + 1'b1;
          res[n]       = build_send(tx_next);
          n++;
          tx_next      = next_seq(tx_next);
        end
      end
      OP_LINK: begin
        link_up = 1'b1;
      end
      OP_FRAME: begin
        // Drop frames that failed CRC or are too short to hold a header
        if (req.crc_ok && req.frame_length >= LEN_W'(MIN_FRAME_LEN)) begin
          if (req.frame_seq == rx_expect) begin
            payload = int'(req.frame_length) - FRAME_OVERHEAD;
            if (payload < 0) begin
              payload = 0;
            end
            if (payload > PAYLOAD_BYTES) begin
              payload = PAYLOAD_BYTES;
            end
            res[n].action         = ACT_DELIVER;
            res[n].seq_number     = req.frame_seq;
            res[n].deliver_length = LEN_W'(payload);
            n++;
            rx_expect = next_seq(rx_expect);
          end
          // Release every outstanding frame up to the piggybacked ack
          for (i = 0; i < SEQ_SPAN && ack_covers(tx_oldest, req.rx_ack, tx_next);
               i++) begin
            res[n]            = '0;
            res[n].action     = ACT_STOP;
            res[n].seq_number = tx_oldest;
            n++;
            if (tx_in_flight != '0) begin
              tx_in_flight = tx_in_flight - 1'b1;
            end
            tx_oldest = next_seq(tx_oldest);
          end
        end
      end
      default: begin
        // Rewind and resend the whole outstanding window
        tx_next = tx_oldest;
        resend  = tx_in_flight;
        for (i = 0; i < int'(resend) && i < SEQ_SPAN; i++) begin
          res[n] = build_send(tx_next);
          n++;
          tx_next = next_seq(tx_next);
        end
      end
    endcase
    if (n == 0) begin
      res[0]        = '0;
      res[0].action = ACT_STATUS;
      n             = 1;
    end
    en = (tx_in_flight < SEQ_W'(SEQ_MAX)) && link_up;
    for (i = 0; i < n; i++) begin
      res[i].net_enable = en;
      res[i].last       = (i == n - 1);
      expected_results.push_back(res[i]);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting and result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  task automatic check_result(input gbn_out_t got);
    gbn_out_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending, action %0d",
                                got.action));
    end else begin
      want = expected_results.pop_front();
      check_field("action",         32'(got.action),         32'(want.action));
      check_field("seq_number",     32'(got.seq_number),     32'(want.seq_number));
      check_field("ack_number",     32'(got.ack_number),     32'(want.ack_number));
      check_field("deliver_length", 32'(got.deliver_length), 32'(want.deliver_length));
      check_field("net_enable",     32'(got.net_enable),     32'(want.net_enable));
      check_field("last",           32'(got.last),           32'(want.last));
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: check strobed results first, then predict any request taken at
  // this edge, since its results can appear no earlier than the next edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      tx_next      <= '0;
      tx_oldest    <= '0;
      rx_expect    <= '0;
      tx_in_flight <= '0;
      link_up      <= 1'b0;
      taken_count  <= 0;
    end else begin
      if (out_strobe) begin
        check_result(out_result);
      end
      if (start && !busy) begin
        predict_link_event(in_request);
        taken_count <= taken_count + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: advance on the falling edge. Once the request on the bus has been
  // taken, draw the idle cycles before the next one; a draw of zero presents
  // the next request at once, so start stays high for back-to-back requests.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    int wait_draw;
    if (!rst_n) begin
      start      <= 1'b0;
      in_request <= '0;
      sent_count <= 0;
      gap_left   <= 0;
      burst_left <= 0;
    end else if (start && taken_count == sent_count) begin
      // Mostly random gaps, with the odd stretch of back-to-back requests
      if (burst_left > 0) begin
        burst_left <= burst_left - 1;
        wait_draw = 0;
      end else begin
        wait_draw = $urandom_range(0, 14);
        if ($urandom_range(0, 19) == 0) begin
          burst_left <= $urandom_range(10, 30);
        end
      end
      if (wait_draw == 0 && pending_requests.size() != 0) begin
        in_request <= pending_requests.pop_front();
        sent_count <= sent_count + 1;
        gap_left   <= 0;
      end else begin
        start    <= 1'b0;
        gap_left <= (wait_draw > 0) ? wait_draw - 1 : 0;
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() != 0) begin
        in_request <= pending_requests.pop_front();
        sent_count <= sent_count + 1;
        start      <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic gbn_in_t make_request(input gbn_op_t op,
                                           input int seq, input int ack,
                                           input int len, input bit crc);
    gbn_in_t r;
    r.operation    = op;
    r.frame_seq    = SEQ_W'(seq);
    r.rx_ack       = SEQ_W'(ack);
    r.frame_length = LEN_W'(len);
    r.crc_ok       = crc;
    return r;
  endfunction

  task automatic queue_request(input gbn_in_t req);
    pending_requests.push_back(req);
    queued_count++;
  endtask

  // Draw one random event, steered by the current window so that most frames
  // arrive in order and most acks land inside the outstanding window
  function automatic gbn_in_t draw_link_event();
    gbn_in_t r;
    int      pick;
    r    = gbn_in_t'(IN_W'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      r.operation = OP_PACKET;
    end else if (pick < 42) begin
      r.operation = OP_LINK;
    end else if (pick < 85) begin
      r.operation = OP_FRAME;
      r.crc_ok    = ($urandom_range(0, 9) != 0);
      pick        = $urandom_range(0, 9);
      if (pick < 8) begin
        r.frame_length = LEN_W'($urandom_range(MIN_FRAME_LEN, 263));
      end else if (pick == 8) begin
        r.frame_length = LEN_W'($urandom_range(0, FRAME_OVERHEAD + 1));
      end else begin
        r.frame_length = LEN_W'($urandom_range(0, 511));
      end
      if ($urandom_range(0, 3) != 0) begin
        r.frame_seq = rx_expect;
      end
      if ($urandom_range(0, 9) < 7) begin
        r.rx_ack = SEQ_W'(tx_oldest + SEQ_W'($urandom_range(0, int'(tx_in_flight))));
      end
    end else begin
      r.operation = OP_TIMEOUT;
    end
    return r;
  endfunction

  initial begin
    int k;
    int drain;
    queued_count = 0;
    error_count  = 0;

    // Fill the window: the eighth packet finds it full and is rejected
    queue_request(make_request(OP_LINK, 0, 0, 0, 1'b0));
    for (k = 0; k < SEQ_SPAN; k++) begin
      queue_request(make_request(OP_PACKET, 7, 7, 511, 1'b1));
    end
    // Resend the full window of seven frames
    queue_request(make_request(OP_TIMEOUT, 0, 0, 0, 1'b0));
    // In-order frame with a full payload whose ack releases the whole window
    queue_request(make_request(OP_FRAME, 0, 6, 263, 1'b1));
    // Short frames deliver empty payloads, length just below the minimum is dropped
    queue_request(make_request(OP_FRAME, 1, 0, MIN_FRAME_LEN, 1'b1));
    queue_request(make_request(OP_FRAME, 2, 0, 6, 1'b1));
    queue_request(make_request(OP_FRAME, 3, 0, MIN_FRAME_LEN - 1, 1'b1));
    // Bad CRC is dropped, out-of-order frame delivers nothing
    queue_request(make_request(OP_FRAME, 3, 0, 100, 1'b0));
    queue_request(make_request(OP_FRAME, 7, 0, 100, 1'b1));
    // Largest length saturates the payload
    queue_request(make_request(OP_FRAME, 3, 0, 511, 1'b1));
    // Timeout with nothing in flight
    queue_request(make_request(OP_TIMEOUT, 5, 5, 0, 1'b1));
    // One frame out, then an ack outside the window releases nothing
    queue_request(make_request(OP_LINK, 0, 0, 0, 1'b0));
    queue_request(make_request(OP_PACKET, 0, 0, 0, 1'b0));
    queue_request(make_request(OP_FRAME, 6, 5, 64, 1'b1));
    // Payload boundaries around the frame overhead
    queue_request(make_request(OP_FRAME, 4, 0, FRAME_OVERHEAD, 1'b1));
    queue_request(make_request(OP_FRAME, 5, 7, FRAME_OVERHEAD + 1, 1'b1));

    // Feed random events one at a time so each draw sees a recent window
    @(posedge rst_n);
    for (k = 0; k < RANDOM_EVENTS; k++) begin
      while (pending_requests.size() != 0) begin
        @(posedge clk);
      end
      queue_request(draw_link_event());
    end

    // Wait for every request to be taken and every result to arrive
    drain = 0;
    while ((taken_count != queued_count || expected_results.size() != 0) &&
           drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    if (drain >= DRAIN_LIMIT) begin
      $display("CHECKS FAILED");
    end else begin
      // Leave room for any stray result after the last expected one
      repeat (SETTLE_CYCLES) @(posedge clk);
      if (error_count == 0) begin
        $display("ALL CHECKS PASSED");
      end else begin
        $display("CHECKS FAILED");
      end
    end
    $finish;
  end

  // Watchdog: end a hung run
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
sv/gbn_pkg.sv
sv/go_back_n_window_controller.sv
tb/go_back_n_window_controller_test.sv
